// ----- rtl/crl_pkg.sv -----
// Shared types, constants and field helpers for the colour ramp lookup block.
// Used by every module under rtl; depends on nothing else.
package crl_pkg;

  // Field widths fixed by the register and sample formats.
  localparam int POS_W      = 16;
  localparam int CHAN_W     = 8;
  localparam int STOP_W     = 40;
  localparam int COUNT_W    = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 40;
  localparam int NUM_CH     = 3;

  // The product of an 8-bit colour step and a 16-bit offset.
  localparam int NUM_W      = CHAN_W + POS_W;
  // The quotient never exceeds the colour step, so eight bits are enough.
  localparam int DIV_STEPS  = CHAN_W;

  typedef logic signed [POS_W-1:0]  pos_t;
  typedef logic [POS_W-1:0]         upos_t;
  typedef logic [CHAN_W-1:0]        chan_t;
  // Index 2 is red, 1 is green, 0 is blue, matching the stop word packing.
  typedef logic [NUM_CH-1:0][CHAN_W-1:0] rgb_t;
  typedef logic [STOP_W-1:0]        stop_word_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STOP_COUNT = 3'd0,
    REG_DISCRETE   = 3'd1,
    REG_STOP0      = 3'd2
  } cfg_reg_t;

  // One divider stage's payload: base colour, sign of each step, divisor,
  // partial remainders and partial quotients.
  typedef struct packed {
    logic                           valid;
    rgb_t                           lo;
    logic [NUM_CH-1:0]              neg;
    upos_t                          den;
    logic [NUM_CH-1:0][NUM_W-1:0]   rem;
    logic [NUM_CH-1:0][CHAN_W-1:0]  quo;
  } div_t;

  // Signed position held in bits 39:24 of a stop word.
  function automatic pos_t stop_pos(input stop_word_t word);
    stop_pos = pos_t'(word[STOP_W-1:NUM_CH*CHAN_W]);
  endfunction

  // Colour held in bits 23:0 of a stop word.
  function automatic rgb_t stop_rgb(input stop_word_t word);
    stop_rgb = rgb_t'(word[NUM_CH*CHAN_W-1:0]);
  endfunction

endpackage

// ----- rtl/crl_seg_select.sv -----
// Segment search for the colour ramp: position compares, then a priority pick.
// Depends on crl_pkg for stop word helpers and widths.
module crl_seg_select #(
  parameter int MAX_STOPS = 6,
  parameter int IW        = $clog2(MAX_STOPS)
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  input  crl_pkg::pos_t                            in_sample,
  input  logic [MAX_STOPS-1:0][crl_pkg::STOP_W-1:0] stops,
  input  logic [crl_pkg::COUNT_W-1:0]              stop_count,
  input  logic                                     discrete_mode,
  output logic                                     seg_valid,
  output crl_pkg::pos_t                            seg_sample,
  output logic [IW-1:0]                            seg_idx,
  output logic                                     seg_interp
);
  import crl_pkg::*;

  localparam logic [COUNT_W-1:0] MaxCount = COUNT_W'(MAX_STOPS);
  localparam logic [COUNT_W-1:0] MinCount = COUNT_W'(2);

  logic                   s1_valid_r;
  pos_t                   s1_sample_r;
  logic [MAX_STOPS-1:0]   le_r;
  logic [MAX_STOPS-2:0]   ordered_r;
  logic [MAX_STOPS-1:0]   le_nxt;
  logic [MAX_STOPS-2:0]   ordered_nxt;

  logic                   s2_valid_r;
  pos_t                   s2_sample_r;
  logic [IW-1:0]          s2_idx_r;
  logic                   s2_interp_r;
  logic [IW-1:0]          idx_nxt;
  logic                   interp_nxt;
  logic [COUNT_W-1:0]     count_eff;

  // Stage 1: compare the sample against every stop, and each stop against the next.
  always_comb begin
    for (int k = 0; k < MAX_STOPS; k++) begin
      le_nxt[k] = in_sample <= stop_pos(stops[k]);
    end
    for (int k = 0; k < MAX_STOPS - 1; k++) begin
      ordered_nxt[k] = stop_pos(stops[k+1]) > stop_pos(stops[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
    end
    s1_sample_r <= in_sample;
    le_r        <= le_nxt;
    ordered_r   <= ordered_nxt;
  end

  // Saturate the stop count into the supported range.
  always_comb begin
    if (stop_count < MinCount) begin
      count_eff = MinCount;
    end else if (stop_count > MaxCount) begin
      count_eff = MaxCount;
    end else begin
      count_eff = stop_count;
    end
  end

  // Stage 2: the lowest closing stop wins; below stop 0 gives stop 0,
  // above the last active stop gives the last stop.
  always_comb begin
    idx_nxt    = IW'(count_eff - 1'b1);
    interp_nxt = 1'b0;
    for (int i = MAX_STOPS - 2; i >= 0; i--) begin
      if ((i + 1) < int'(count_eff) && le_r[i+1]) begin
        idx_nxt    = IW'(i);
        interp_nxt = ordered_r[i] && !discrete_mode;
      end
    end
    if (le_r[0]) begin
      idx_nxt    = '0;
      interp_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
    s2_sample_r <= s1_sample_r;
    s2_idx_r    <= idx_nxt;
    s2_interp_r <= interp_nxt;
  end

  assign seg_valid  = s2_valid_r;
  assign seg_sample = s2_sample_r;
  assign seg_idx    = s2_idx_r;
  assign seg_interp = s2_interp_r;

endmodule

// ----- rtl/crl_scale.sv -----
// Operand setup and colour step scaling for the colour ramp.
// Depends on crl_pkg for the divider payload type and field helpers.
module crl_scale #(
  parameter int MAX_STOPS = 6,
  parameter int IW        = $clog2(MAX_STOPS)
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     seg_valid,
  input  crl_pkg::pos_t                            seg_sample,
  input  logic [IW-1:0]                            seg_idx,
  input  logic                                     seg_interp,
  input  logic [MAX_STOPS-1:0][crl_pkg::STOP_W-1:0] stops,
  output crl_pkg::div_t                            div_out
);
  import crl_pkg::*;

  logic [IW-1:0]                  hi_idx;
  stop_word_t                     lo_word;
  stop_word_t                     hi_word;
  rgb_t                           lo_rgb;
  rgb_t                           hi_rgb;
  logic signed [POS_W:0]          dv_full;
  logic signed [POS_W:0]          den_full;
  logic signed [CHAN_W:0]         step;

  logic                           s3_valid_r;
  rgb_t                           s3_lo_r;
  logic [NUM_CH-1:0]              s3_neg_r;
  logic [NUM_CH-1:0][CHAN_W-1:0]  s3_mag_r;
  upos_t                          s3_dv_r;
  upos_t                          s3_den_r;
  logic [NUM_CH-1:0]              neg_nxt;
  logic [NUM_CH-1:0][CHAN_W-1:0]  mag_nxt;
  upos_t                          dv_nxt;
  upos_t                          den_nxt;

  div_t                           s4_r;
  div_t                           s4_nxt;

  // Stage 3: pick the segment's stops and form the offsets and colour steps.
  // A pass-through colour uses a zero step over a unit divisor.
  always_comb begin
    hi_idx   = seg_interp ? IW'(seg_idx + 1'b1) : seg_idx;
    lo_word  = stops[seg_idx];
    hi_word  = stops[hi_idx];
    lo_rgb   = stop_rgb(lo_word);
    hi_rgb   = stop_rgb(hi_word);
    dv_full  = (POS_W+1)'(seg_sample) - (POS_W+1)'(stop_pos(lo_word));
    den_full = (POS_W+1)'(stop_pos(hi_word)) - (POS_W+1)'(stop_pos(lo_word));
    step     = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      step       = $signed({1'b0, hi_rgb[c]}) - $signed({1'b0, lo_rgb[c]});
      neg_nxt[c] = step[CHAN_W];
      mag_nxt[c] = step[CHAN_W] ? CHAN_W'(-step) : step[CHAN_W-1:0];
    end
    if (seg_interp) begin
      dv_nxt  = dv_full[POS_W-1:0];
      den_nxt = den_full[POS_W-1:0];
    end else begin
      dv_nxt  = '0;
      den_nxt = upos_t'(1);
      neg_nxt = '0;
      mag_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= seg_valid;
    end
    s3_lo_r  <= lo_rgb;
    s3_neg_r <= neg_nxt;
    s3_mag_r <= mag_nxt;
    s3_dv_r  <= dv_nxt;
    s3_den_r <= den_nxt;
  end

  // Stage 4: scale each colour step by the sample offset.
  always_comb begin
    s4_nxt.valid = s3_valid_r;
    s4_nxt.lo    = s3_lo_r;
    s4_nxt.neg   = s3_neg_r;
    s4_nxt.den   = s3_den_r;
    s4_nxt.quo   = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      s4_nxt.rem[c] = NUM_W'(s3_mag_r[c]) * NUM_W'(s3_dv_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_r.valid <= 1'b0;
    end else begin
      s4_r.valid <= s4_nxt.valid;
    end
    s4_r.lo  <= s4_nxt.lo;
    s4_r.neg <= s4_nxt.neg;
    s4_r.den <= s4_nxt.den;
    s4_r.rem <= s4_nxt.rem;
    s4_r.quo <= s4_nxt.quo;
  end

  assign div_out = s4_r;

endmodule

// ----- rtl/crl_div_pipe.sv -----
// Pipelined restoring divider, one quotient bit per stage for all channels.
// Depends on crl_pkg for the divider payload type.
module crl_div_pipe (
  input  logic          clk,
  input  logic          rst_n,
  input  crl_pkg::div_t div_in,
  output crl_pkg::div_t div_out
);
  import crl_pkg::*;

  div_t stage_r [DIV_STEPS+1];

  assign stage_r[0] = div_in;

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_stage
    localparam int Bit = DIV_STEPS - 1 - s;

    div_t                  nxt;
    logic [NUM_W:0]        trial [NUM_CH];

    // Try to take the divisor shifted to this quotient bit from each remainder.
    always_comb begin
      nxt = stage_r[s];
      for (int c = 0; c < NUM_CH; c++) begin
        trial[c] = {1'b0, stage_r[s].rem[c]} - ((NUM_W+1)'(stage_r[s].den) << Bit);
        if (!trial[c][NUM_W]) begin
          nxt.rem[c]      = trial[c][NUM_W-1:0];
          nxt.quo[c][Bit] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stage_r[s+1].valid <= 1'b0;
      end else begin
        stage_r[s+1].valid <= nxt.valid;
      end
      stage_r[s+1].lo  <= nxt.lo;
      stage_r[s+1].neg <= nxt.neg;
      stage_r[s+1].den <= nxt.den;
      stage_r[s+1].rem <= nxt.rem;
      stage_r[s+1].quo <= nxt.quo;
    end
  end

  assign div_out = stage_r[DIV_STEPS];

endmodule

// ----- rtl/colour_ramp_lookup_core.sv -----
// Colour ramp lookup: maps a signed sample to RGB through up to MAX_STOPS stops.
// A sample passes 13 register stages (two segment search, setup, multiply, eight divider,
// output), the first loaded at the accepting edge. Throughput is one transaction per cycle
// once busy is low; busy is registered: high during reset, low from the first edge after.
// Reset (synchronous, active low) restores the default black-to-white ramp and empties the
// pipeline; the receiver cannot stall. Uses crl_pkg.
module colour_ramp_lookup_core #(
  parameter int MAX_STOPS = 6
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  crl_pkg::pos_t                     in_sample_value,
  output logic                              out_valid,
  output crl_pkg::chan_t                    out_red,
  output crl_pkg::chan_t                    out_green,
  output crl_pkg::chan_t                    out_blue,
  input  logic                              cfg_we,
  input  logic [crl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [crl_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import crl_pkg::*;

  localparam int IW = $clog2(MAX_STOPS);
  localparam stop_word_t Stop1Reset = stop_word_t'(40'h00_01FF_FFFF);

  logic                              busy_r;
  logic [COUNT_W-1:0]                stop_count_r;
  logic                              discrete_r;
  logic [MAX_STOPS-1:0][STOP_W-1:0]  stops_r;

  logic                              seg_valid;
  pos_t                              seg_sample;
  logic [IW-1:0]                     seg_idx;
  logic                              seg_interp;
  div_t                              scaled;
  div_t                              divided;

  logic                              out_valid_r;
  rgb_t                              out_rgb_r;
  rgb_t                              out_rgb_nxt;

  // Busy registers reset only; afterwards a transaction enters every cycle that start is high.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;

  // Configuration registers. Writes to stops beyond MAX_STOPS are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_count_r <= COUNT_W'(2);
      discrete_r   <= 1'b0;
      for (int k = 0; k < MAX_STOPS; k++) begin
        stops_r[k] <= (k == 1) ? Stop1Reset : '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == REG_STOP_COUNT) begin
        stop_count_r <= cfg_wdata[COUNT_W-1:0];
      end
      if (cfg_index == REG_DISCRETE) begin
        discrete_r <= cfg_wdata[0];
      end
      for (int k = 0; k < MAX_STOPS; k++) begin
        if (cfg_index == CFG_IDX_W'(REG_STOP0 + k)) begin
          stops_r[k] <= cfg_wdata[STOP_W-1:0];
        end
      end
    end
  end

  crl_seg_select #(
    .MAX_STOPS (MAX_STOPS),
    .IW        (IW)
  ) u_seg (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (start && !busy_r),
    .in_sample     (in_sample_value),
    .stops         (stops_r),
    .stop_count    (stop_count_r),
    .discrete_mode (discrete_r),
    .seg_valid     (seg_valid),
    .seg_sample    (seg_sample),
    .seg_idx       (seg_idx),
    .seg_interp    (seg_interp)
  );

  crl_scale #(
    .MAX_STOPS (MAX_STOPS),
    .IW        (IW)
  ) u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .seg_valid  (seg_valid),
    .seg_sample (seg_sample),
    .seg_idx    (seg_idx),
    .seg_interp (seg_interp),
    .stops      (stops_r),
    .div_out    (scaled)
  );

  crl_div_pipe u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .div_in  (scaled),
    .div_out (divided)
  );

  // Apply the signed, truncated step to the lower colour, modulo 256.
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      out_rgb_nxt[c] = divided.neg[c] ? divided.lo[c] - divided.quo[c]
                                      : divided.lo[c] + divided.quo[c];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= divided.valid;
    end
    out_rgb_r <= out_rgb_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_rgb_r[2];
  assign out_green = out_rgb_r[1];
  assign out_blue  = out_rgb_r[0];

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for colour_ramp_lookup_core: directed ramps, then random ramps.
// Predicts each colour from its own copy of the stop registers and checks every result.
// Depends on crl_pkg and the colour_ramp_lookup_core RTL.
module testbench;
  import crl_pkg::*;

  localparam int RAMP_STOPS  = 6;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 125;

  // One expected colour, tagged with the sample that produced it.
  typedef struct {
    pos_t  sample;
    chan_t red;
    chan_t green;
    chan_t blue;
  } colour_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  pos_t                  in_sample_value = '0;
  logic                  out_valid;
  chan_t                 out_red;
  chan_t                 out_green;
  chan_t                 out_blue;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Local copy of the ramp configuration, updated on every register write.
  logic [COUNT_W-1:0] ramp_count;
  logic               ramp_discrete;
  logic [STOP_W-1:0]  ramp_stop [RAMP_STOPS];

  colour_t expected_colours[$];
  colour_t want_colour;
  int      fail_count = 0;
  int      cycle_count = 0;
  int      sender_idle_pct = 0;

  colour_ramp_lookup_core #(.MAX_STOPS(RAMP_STOPS)) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_sample_value(in_sample_value),
    .out_valid(out_valid),
    .out_red(out_red),
    .out_green(out_green),
    .out_blue(out_blue),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Stop count saturates to the range the ramp supports.
  function automatic int active_stops();
    int n;
    n = ramp_count;
    if (n < 2) n = 2;
    if (n > RAMP_STOPS) n = RAMP_STOPS;
    return n;
  endfunction

  function automatic int stop_position(input int k);
    pos_t p;
    p = ramp_stop[k][STOP_W-1 -: POS_W];
    return int'(p);
  endfunction

  // Channel 0 is red, 1 green, 2 blue.
  function automatic int stop_channel(input int k, input int ch);
    return int'(ramp_stop[k][16 - 8 * ch +: 8]);
  endfunction

  function automatic colour_t stop_colour(input int k, input pos_t sample);
    colour_t c;
    c.sample = sample;
    c.red    = chan_t'(stop_channel(k, 0));
    c.green  = chan_t'(stop_channel(k, 1));
    c.blue   = chan_t'(stop_channel(k, 2));
    return c;
  endfunction

  // Colour that the ramp assigns to one sample under the current configuration.
  function automatic colour_t ramp_colour(input pos_t sample);
    colour_t c;
    chan_t   rgb [3];
    int      v, n, plo, phi;
    longint  lo, hi, q;
    v = int'(sample);
    n = active_stops();
    c.sample = sample;
    if (v <= stop_position(0)) return stop_colour(0, sample);
    for (int i = 0; i + 1 < n; i++) begin
      plo = stop_position(i);
      phi = stop_position(i + 1);
      if (v <= phi) begin
        if (ramp_discrete || phi <= plo) return stop_colour(i, sample);
        // Division truncates toward zero, so falling channels round up.
        for (int ch = 0; ch < 3; ch++) begin
          lo = stop_channel(i, ch);
          hi = stop_channel(i + 1, ch);
          q = ((hi - lo) * longint'(v - plo)) / longint'(phi - plo);
          rgb[ch] = chan_t'(lo + q);
        end
        c.red   = rgb[0];
        c.green = rgb[1];
        c.blue  = rgb[2];
        return c;
      end
    end
    return stop_colour(n - 1, sample);
  endfunction

  function automatic logic [STOP_W-1:0] make_stop(input int pos, input logic [23:0] rgb);
    logic [POS_W-1:0] p;
    p = pos[POS_W-1:0];
    return {p, rgb};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_word();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[CFG_DATA_W-1:0];
  endfunction

  // Stop sending and wait until every outstanding transaction has returned.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (expected_colours.size() != 0) @(posedge clk);
  endtask

  // Register writes happen only with the pipeline empty.
  task automatic set_reg(input int idx, input logic [CFG_DATA_W-1:0] data);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IDX_W'(idx);
    cfg_wdata <= data;
    @(posedge clk);
    if (idx == REG_STOP_COUNT) begin
      ramp_count = data[COUNT_W-1:0];
    end else if (idx == REG_DISCRETE) begin
      ramp_discrete = data[0];
    end else if (idx >= REG_STOP0 && idx < REG_STOP0 + RAMP_STOPS) begin
      ramp_stop[idx - REG_STOP0] = data[STOP_W-1:0];
    end
  endtask

  // Offer one sample, record its colour once accepted, then idle at random.
  task automatic send_sample(input pos_t sample);
    start           <= 1'b1;
    in_sample_value <= sample;
    cfg_we          <= 1'b0;
    do @(posedge clk); while (busy);
    expected_colours.push_back(ramp_colour(sample));
    while (int'($urandom_range(99)) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Compare each result transaction against the oldest expected colour.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_colours.size() == 0) begin
        if (fail_count < 10)
          $display("Unexpected result: r=%0d g=%0d b=%0d", out_red, out_green, out_blue);
        fail_count <= fail_count + 1;
      end else begin
        want_colour = expected_colours.pop_front();
        if (out_red !== want_colour.red || out_green !== want_colour.green ||
            out_blue !== want_colour.blue) begin
          if (fail_count < 10)
            $display("Mismatch for sample %0d: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                     want_colour.sample, want_colour.red, want_colour.green, want_colour.blue,
                     out_red, out_green, out_blue);
          fail_count <= fail_count + 1;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // The reset ramp runs from black at position 0 to white at position 1.
  task automatic test_default_ramp();
    send_sample(-32768);
    send_sample(-1);
    send_sample(0);
    send_sample(1);
    send_sample(32767);
  endtask

  // Full six-stop ramp spanning the whole sample range, with rising and falling channels.
  task automatic test_sorted_ramp();
    set_reg(REG_STOP_COUNT, 40'd6);
    set_reg(REG_DISCRETE, 40'd0);
    set_reg(REG_STOP0 + 0, make_stop(-32768, 24'h00_00_00));
    set_reg(REG_STOP0 + 1, make_stop(-20000, 24'hFF_00_80));
    set_reg(REG_STOP0 + 2, make_stop(0, 24'h10_FF_20));
    set_reg(REG_STOP0 + 3, make_stop(1, 24'h80_80_80));
    set_reg(REG_STOP0 + 4, make_stop(20000, 24'h00_FF_FF));
    set_reg(REG_STOP0 + 5, make_stop(32767, 24'hFF_00_00));
    send_sample(-32768);
    send_sample(-32767);
    send_sample(-20001);
    send_sample(-1);
    send_sample(0);
    send_sample(1);
    send_sample(2);
    send_sample(32766);
    send_sample(32767);
  endtask

  // Discrete mode picks the lower stop of each segment; upper data bits are ignored.
  task automatic test_discrete_mode();
    set_reg(REG_DISCRETE, 40'd1);
    send_sample(-19995);
    send_sample(10000);
    send_sample(32767);
    set_reg(REG_DISCRETE, 40'hFF_FFFF_FFFE);
  endtask

  // Zero-width and unsorted segments fall back to the lower stop colour.
  task automatic test_degenerate_stops();
    set_reg(REG_STOP_COUNT, 40'd4);
    set_reg(REG_STOP0 + 0, make_stop(100, 24'h20_40_60));
    set_reg(REG_STOP0 + 1, make_stop(100, 24'hA0_B0_C0));
    set_reg(REG_STOP0 + 2, make_stop(50, 24'hFF_10_01));
    set_reg(REG_STOP0 + 3, make_stop(300, 24'h00_F0_FE));
    send_sample(100);
    send_sample(101);
    send_sample(200);
    send_sample(400);
  endtask

  // Stop counts outside the supported range saturate.
  task automatic test_stop_count_limits();
    set_reg(REG_STOP_COUNT, 40'hFF_FFFF_FFF8);
    send_sample(32767);
    set_reg(REG_STOP_COUNT, 40'd1);
    send_sample(32767);
    set_reg(REG_STOP_COUNT, 40'd7);
    send_sample(250);
    send_sample(32767);
  endtask

  // Program every register with a random ramp; phase picks the stop count extremes.
  task automatic program_random_ramp(input int phase);
    int pos [RAMP_STOPS];
    int shape, count, base, swap;
    logic disc;
    shape = $urandom_range(3);
    case (phase)
      0:       count = 2;
      1:       count = 6;
      default: count = ($urandom_range(4) == 0) ? $urandom_range(7) : $urandom_range(2, 6);
    endcase
    disc = (phase == 2) || ($urandom_range(2) == 0);
    base = int'($urandom_range(60000)) - 30000;
    for (int k = 0; k < RAMP_STOPS; k++) begin
      if (shape == 1) begin
        // Tightly clustered stops give narrow and zero-width segments.
        base = base + int'($urandom_range(40));
        pos[k] = base;
      end else begin
        pos[k] = int'($urandom_range(65535)) - 32768;
      end
    end
    if (shape == 0 || shape == 3) begin
      for (int a = 0; a < RAMP_STOPS - 1; a++)
        for (int b = 0; b < RAMP_STOPS - 1 - a; b++)
          if (pos[b] > pos[b + 1]) begin
            swap = pos[b];
            pos[b] = pos[b + 1];
            pos[b + 1] = swap;
          end
    end
    if (shape == 3) begin
      pos[0] = -32768;
      pos[(count < 2) ? 1 : (count > RAMP_STOPS) ? RAMP_STOPS - 1 : count - 1] = 32767;
    end
    set_reg(REG_STOP_COUNT, (rand_word() & ~40'h7) | CFG_DATA_W'(count));
    set_reg(REG_DISCRETE, (rand_word() & ~40'h1) | CFG_DATA_W'(disc));
    for (int k = 0; k < RAMP_STOPS; k++)
      set_reg(REG_STOP0 + k, make_stop(pos[k], 24'(rand_word())));
  endtask

  // Mostly samples inside or near the active stops, some over the full range.
  function automatic pos_t pick_sample();
    int n, lo, hi, k;
    n = active_stops();
    case ($urandom_range(9))
      0, 1: return pos_t'(int'($urandom_range(65535)));
      2, 3, 4: begin
        k = $urandom_range(n - 1);
        return pos_t'(stop_position(k) + int'($urandom_range(4)) - 2);
      end
      default: begin
        lo = stop_position(0);
        hi = lo;
        for (int i = 1; i < n; i++) begin
          if (stop_position(i) < lo) lo = stop_position(i);
          if (stop_position(i) > hi) hi = stop_position(i);
        end
        return pos_t'(lo + int'($urandom_range(hi - lo)));
      end
    endcase
  endfunction

  // Random ramps under changing sender idling, with a full drain in every phase.
  task automatic test_random_ramps();
    int idle_pattern [4] = '{0, 76, 8, 0};
    for (int phase = 0; phase < PHASES; phase++) begin
      program_random_ramp(phase);
      sender_idle_pct = idle_pattern[phase % 4];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) drain_results();
        send_sample(pick_sample());
      end
    end
    sender_idle_pct = 0;
  endtask

  initial begin
    ramp_count    = 3'd2;
    ramp_discrete = 1'b0;
    for (int k = 0; k < RAMP_STOPS; k++) ramp_stop[k] = '0;
    ramp_stop[1] = 40'h00_01FF_FFFF;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_default_ramp();
    test_sorted_ramp();
    test_discrete_mode();
    test_degenerate_stops();
    test_stop_count_limits();
    test_random_ramps();
    drain_results();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && expected_colours.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
